@@ hdl/ccwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ccwc_pkg;

  localparam int FRAME_RATE_W        = 10;
  localparam int HOUR_W              = 5;
  localparam int MIN_W               = 6;
  localparam int SEC_W               = 6;
  localparam int MODE_W              = 2;
  localparam int TICK_COUNTER_BITS_D = 10;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [FRAME_RATE_W-1:0] FRAME_RATE_RST = 10'd50;
  localparam logic [SEC_W-1:0]        SEC_PER_MIN    = 6'd60;
  localparam logic [MIN_W-1:0]        MIN_PER_HOUR   = 6'd60;
  localparam logic [HOUR_W-1:0]       HOUR_PER_DAY   = 5'd24;

  // register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_FRAME_RATE    = 2'd0,
    REG_START_HOURS   = 2'd1,
    REG_START_MINUTES = 2'd2,
    REG_START_SECONDS = 2'd3
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FWD  = 2'd0,
    MODE_BACK = 2'd1,
    MODE_STOP = 2'd2
  } mode_t;

  typedef struct packed {
    logic [FRAME_RATE_W-1:0] frame_rate;
    logic [HOUR_W-1:0]       start_hours;
    logic [MIN_W-1:0]        start_minutes;
    logic [SEC_W-1:0]        start_seconds;
  } cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } hms_t;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [MODE_W-1:0] timer_mode;
    logic [SEC_W-1:0]  timer_seconds;
    logic [MIN_W-1:0]  timer_minutes;
    logic [HOUR_W-1:0] timer_hours;
    logic [SEC_W-1:0]  clock_seconds;
    logic [MIN_W-1:0]  clock_minutes;
    logic [HOUR_W-1:0] clock_hours;
  } result_t;

  // one second forward; out-of-range fields wrap to zero and carry
  function automatic hms_t advance_hms(input hms_t t);
    hms_t r;
    r = t;
    r.seconds = t.seconds + SEC_W'(1);
    if (r.seconds >= SEC_PER_MIN) begin
      r.seconds = '0;
      r.minutes = t.minutes + MIN_W'(1);
      if (r.minutes >= MIN_PER_HOUR) begin
        r.minutes = '0;
        r.hours = t.hours + HOUR_W'(1);
        if (r.hours >= HOUR_PER_DAY) begin
          r.hours = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cockpit_clock_with_chronometer.sv @@
// Cockpit time-of-day clock with a chronometer, advanced one frame tick per
// input transaction.
//   s_* stream: one transaction per frame tick, s_tdata[0] = held,
//               s_tdata[1] = button.
//   m_* stream: one transaction per input, the clock and chronometer after
//               that tick (see m_tdata for the field layout).
//   APB port:   frame_rate at 0x0, start hours/minutes/seconds at 0x4, 0x8,
//               0xC. Write only while the streams are idle. pready is tied high.
// A tick accepted on s_* is registered into the result register, or into
// the skid register while a result waits. Throughput is one tick per clock
// while s_tready is high; the whole update is two counter bumps plus compares
// and an hh:mm:ss carry chain, done between the state and result registers.
// A two-entry output stage (result register plus skid register) keeps
// s_tready high while one result waits; s_tready drops only once both are
// full, and rises again the cycle after the receiver takes a result.
// Reset clears the tick counters, the chronometer (forwards mode) and the
// clock, restores the register defaults (frame rate 50) and empties the
// output stage. The clock loads the start registers on the first tick that
// is not held.
`timescale 1ns / 1ps
`default_nettype none

module cockpit_clock_with_chronometer #(
  parameter int TICK_COUNTER_BITS = ccwc_pkg::TICK_COUNTER_BITS_D
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ccwc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [ccwc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [ccwc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [0] held, [1] button, [7:2] zero
  input  wire logic [ccwc_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [4:0] clock_hours, [10:5] clock_minutes, [16:11] clock_seconds,
  // [21:17] timer_hours, [27:22] timer_minutes, [33:28] timer_seconds,
  // [35:34] timer_mode, [39:36] zero
  output logic      [ccwc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int TW    = TICK_COUNTER_BITS;
  localparam int CMP_W = (TW > ccwc_pkg::FRAME_RATE_W) ? TW : ccwc_pkg::FRAME_RATE_W;

  ccwc_pkg::cfg_t cfg;

  ccwc_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // wraps at frame_rate, and at the counter width in any case
  function automatic logic [TW-1:0] bump(input logic [TW-1:0] c,
                                         input logic [ccwc_pkg::FRAME_RATE_W-1:0] fr);
    logic [TW-1:0] n;
    n = c + TW'(1);
    return (CMP_W'(n) >= CMP_W'(fr)) ? '0 : n;
  endfunction

  // state
  logic [TW-1:0]         sys_ticks, sys_ticks_next;
  logic [TW-1:0]         clk_ticks, clk_ticks_next;
  ccwc_pkg::hms_t        clock_t, clock_t_next;
  ccwc_pkg::hms_t        timer_t, timer_t_next;
  ccwc_pkg::mode_t       mode, mode_next;
  logic                  started, started_next;

  // output stage
  ccwc_pkg::result_t     result_next;
  ccwc_pkg::result_t     out_reg;
  ccwc_pkg::result_t     skid_reg;
  logic                  out_valid;
  logic                  skid_valid;

  logic held;
  logic button;
  logic in_fire;
  logic out_fire;

  assign held     = s_tdata[0];
  assign button   = s_tdata[1];
  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

  always_comb begin
    sys_ticks_next = bump(sys_ticks, cfg.frame_rate);
    clk_ticks_next = clk_ticks;
    clock_t_next   = clock_t;
    timer_t_next   = timer_t;
    mode_next      = mode;
    started_next   = started;

    if (!held) begin
      if (!started) begin
        clock_t_next.hours   = cfg.start_hours;
        clock_t_next.minutes = cfg.start_minutes;
        clock_t_next.seconds = cfg.start_seconds;
        started_next         = 1'b1;
      end

      if (button) begin
        priority if (mode == ccwc_pkg::MODE_FWD) begin
          mode_next            = ccwc_pkg::MODE_BACK;
          timer_t_next.minutes = '0;
          timer_t_next.hours   = '0;
        end else if (mode == ccwc_pkg::MODE_STOP) begin
          mode_next = ccwc_pkg::MODE_FWD;
        end else begin
          mode_next = mode;
        end
      end

      if (mode_next == ccwc_pkg::MODE_BACK) begin
        if (timer_t.seconds <= ccwc_pkg::SEC_W'(1)) begin
          timer_t_next.seconds = '0;
          mode_next            = ccwc_pkg::MODE_STOP;
        end else if (sys_ticks_next != '0) begin
          timer_t_next.seconds = timer_t.seconds - ccwc_pkg::SEC_W'(1);
        end
      end

      clk_ticks_next = bump(clk_ticks, cfg.frame_rate);
      if (clk_ticks_next == '0) begin
        if (mode_next == ccwc_pkg::MODE_FWD) begin
          timer_t_next = ccwc_pkg::advance_hms(timer_t_next);
        end
        clock_t_next = ccwc_pkg::advance_hms(clock_t_next);
      end
    end
  end

  always_comb begin
    result_next               = '0;
    result_next.clock_hours   = clock_t_next.hours;
    result_next.clock_minutes = clock_t_next.minutes;
    result_next.clock_seconds = clock_t_next.seconds;
    result_next.timer_hours   = timer_t_next.hours;
    result_next.timer_minutes = timer_t_next.minutes;
    result_next.timer_seconds = timer_t_next.seconds;
    result_next.timer_mode    = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_ticks <= '0;
      clk_ticks <= '0;
      clock_t   <= '0;
      timer_t   <= '0;
      mode      <= ccwc_pkg::MODE_FWD;
      started   <= 1'b0;
    end else if (in_fire) begin
      sys_ticks <= sys_ticks_next;
      clk_ticks <= clk_ticks_next;
      clock_t   <= clock_t_next;
      timer_t   <= timer_t_next;
      mode      <= mode_next;
      started   <= started_next;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_fire) begin
        out_reg <= result_next;
      end
    end else if (in_fire) begin
      skid_reg <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ccwc_apb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ccwc_apb (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ccwc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [ccwc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [ccwc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output ccwc_pkg::cfg_t                          cfg
);

  ccwc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = ccwc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_rate    <= ccwc_pkg::FRAME_RATE_RST;
      cfg.start_hours   <= '0;
      cfg.start_minutes <= '0;
      cfg.start_seconds <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ccwc_pkg::REG_FRAME_RATE:
          cfg.frame_rate <= pwdata[ccwc_pkg::FRAME_RATE_W-1:0];
        ccwc_pkg::REG_START_HOURS:
          cfg.start_hours <= pwdata[ccwc_pkg::HOUR_W-1:0];
        ccwc_pkg::REG_START_MINUTES:
          cfg.start_minutes <= pwdata[ccwc_pkg::MIN_W-1:0];
        ccwc_pkg::REG_START_SECONDS:
          cfg.start_seconds <= pwdata[ccwc_pkg::SEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ccwc_pkg::REG_FRAME_RATE:
        prdata = ccwc_pkg::APB_DATA_W'(cfg.frame_rate);
      ccwc_pkg::REG_START_HOURS:
        prdata = ccwc_pkg::APB_DATA_W'(cfg.start_hours);
      ccwc_pkg::REG_START_MINUTES:
        prdata = ccwc_pkg::APB_DATA_W'(cfg.start_minutes);
      ccwc_pkg::REG_START_SECONDS:
        prdata = ccwc_pkg::APB_DATA_W'(cfg.start_seconds);
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ccwc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ccwc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [ccwc_pkg::OUT_DATA_W-1:0] m_tdata
);

  ccwc_pkg::result_t res;
  assign res = m_tdata;

  // output stage empties at reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // input side stalls only while a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("s_tready low with empty output");

  // backwards and stopped modes only follow a clear of the chronometer hours and minutes
  a_chrono_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.timer_mode == ccwc_pkg::MODE_BACK ||
                 res.timer_mode == ccwc_pkg::MODE_STOP)
    |-> res.timer_hours == '0 && res.timer_minutes == '0)
    else $error("chronometer not cleared in backwards or stopped mode");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.timer_mode == ccwc_pkg::MODE_STOP |-> res.timer_seconds == '0)
    else $error("stopped chronometer seconds not zero");

endmodule

bind cockpit_clock_with_chronometer ccwc_checker u_ccwc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
